/* hdl/brf_pkg.sv */
// shared widths, operation codes and status codes of the byte ring fifo
`timescale 1ns / 1ps

package brf_pkg;

  localparam int DEF_DEPTH     = 4096;
  localparam int DEF_MAX_BURST = 64;

  localparam int DATA_W  = 8;
  localparam int OP_W    = 3;
  localparam int LEN_W   = 7;
  localparam int ST_W    = 2;
  localparam int LEVEL_W = 13;
  localparam int CAP_W   = 13;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 3'd0,
    OP_READ      = 3'd1,
    OP_PEEK      = 3'd2,
    OP_SKIP      = 3'd3,
    OP_READ_BLK  = 3'd4,
    OP_PEEK_BLK  = 3'd5
  } op_t;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

/* hdl/byte_ring_fifo.sv */
// byte ring fifo with settable capacity, byte and burst read, peek and skip
//
//  channel | dir | handshake         | content
//  --------+-----+-------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready | request: mode, byte to store, count
//  m_*     | out | m_tvalid/m_tready | result: byte, status, length, level
//  cfg_*   | in  | cfg_we            | capacity register, write only
//
// write, skip, unused-mode, refused and zero-count requests: result loaded at accept
// byte read or peek: result taken from the registered read port of the storage ram via the burst state
// burst read or peek of n bytes: one byte a cycle from the ram while the result moves,
//   pointer stepped by the single shared wrap adder
// reset empties the ring and sets capacity to the full depth; storage needs no clearing pass
// a stalled result holds the block; a new request is taken once the result moves
`timescale 1ns / 1ps

module byte_ring_fifo
  import brf_pkg::*;
#(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int MAX_BURST = DEF_MAX_BURST
) (
  input  logic               clk,
  input  logic               rst,
  // request
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // [7:0] data_in, [14:8] count, [15] zero
  input  logic [OP_W-1:0]    s_tuser,   // [2:0] mode
  // result
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,   // [7:0] data_out, [9:8] status,
                                        // [16:10] length, [29:17] level, [31:30] zero
  output logic               m_tlast,   // last
  // capacity register
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata  // capacity
);

  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = PTR_W + 1;
  localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int SUM_W     = CMP_W + 1;
  localparam int CFG_CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_BURST = 2'b10
  } state_t;

  // storage ram, one write and one registered read port
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;
  logic              mem_we;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_raddr;

  // control state
  state_t            state, state_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [CNT_W-1:0]  capacity;
  logic [PTR_W-1:0]  p, p_next;          // burst fetch pointer
  logic [LEN_W-1:0]  idx, idx_next;      // bytes handed out so far
  logic [LEN_W-1:0]  n_reg, n_next;      // bytes in this burst
  logic              consume, consume_next;

  // output register
  logic [DATA_W-1:0]  out_data, out_data_next;
  logic [ST_W-1:0]    out_status, out_status_next;
  logic [LEN_W-1:0]   out_len, out_len_next;
  logic               out_last, out_last_next;
  logic [LEVEL_W-1:0] out_level, out_level_next;
  logic               load;

  // request decode
  op_t               op;
  logic [DATA_W-1:0] din;
  logic [LEN_W-1:0]  cnt_raw, cnt;
  logic [LEN_W-1:0]  n_min;
  logic              out_free, accept, empty, full, burst_last;

  // shared wrap adder
  logic [PTR_W-1:0]  adv_base;
  logic [LEN_W-1:0]  adv_amt;
  logic [SUM_W-1:0]  adv_sum;
  logic [PTR_W-1:0]  adv_res;

  // capacity clamp
  logic [CFG_CMP_W-1:0] cfg_ext;
  logic [CNT_W-1:0]     cfg_cap;

  assign op      = op_t'(s_tuser);
  assign din     = s_tdata[7:0];
  assign cnt_raw = s_tdata[14:8];
  assign cnt     = (cnt_raw > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : cnt_raw;
  assign n_min   = (CMP_W'(fill) < CMP_W'(cnt)) ? LEN_W'(fill) : cnt;
  assign empty   = (fill == '0);
  assign full    = (fill >= capacity);

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == S_IDLE) && out_free;
  assign accept     = s_tvalid && s_tready;
  assign burst_last = (idx == n_reg - LEN_W'(1));

  // pointer + amount, folded back once below capacity
  assign adv_sum = SUM_W'(adv_base) + SUM_W'(adv_amt);
  assign adv_res = (adv_sum >= SUM_W'(capacity)) ? PTR_W'(adv_sum - SUM_W'(capacity))
                                                 : PTR_W'(adv_sum);

  assign cfg_ext = CFG_CMP_W'(cfg_wdata);
  always_comb begin
    if (cfg_ext == '0) begin
      cfg_cap = CNT_W'(1);
    end else if (cfg_ext > CFG_CMP_W'(DEPTH)) begin
      cfg_cap = CNT_W'(DEPTH);
    end else begin
      cfg_cap = CNT_W'(cfg_ext);
    end
  end

  always_comb begin
    state_next      = state;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    fill_next       = fill;
    p_next          = p;
    idx_next        = idx;
    n_next          = n_reg;
    consume_next    = consume;
    load            = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = rd_ptr;
    adv_base        = rd_ptr;
    adv_amt         = LEN_W'(1);
    out_data_next   = '0;
    out_status_next = ST_OK;
    out_len_next    = '0;
    out_last_next   = 1'b1;
    out_level_next  = LEVEL_W'(fill);

    case (state)
      S_IDLE: begin
        adv_base = (op == OP_WRITE) ? wr_ptr : rd_ptr;
        adv_amt  = (op == OP_SKIP) ? n_min : LEN_W'(1);
        if (accept) begin
          load = 1'b1;
          case (op)
            OP_WRITE: begin
              if (full) begin
                out_status_next = ST_FULL;
              end else begin
                mem_we       = 1'b1;
                wr_ptr_next  = adv_res;
                fill_next    = fill + CNT_W'(1);
                out_len_next = LEN_W'(1);
              end
            end
            OP_READ, OP_PEEK, OP_READ_BLK, OP_PEEK_BLK: begin
              if (empty) begin
                out_status_next = ST_EMPTY;
              end else if ((op inside {OP_READ_BLK, OP_PEEK_BLK}) && n_min == '0) begin
                out_status_next = ST_OK;
              end else begin
                // fetch the first byte now, hand bytes out from the burst state
                load         = 1'b0;
                mem_re       = 1'b1;
                p_next       = adv_res;
                n_next       = (op inside {OP_READ, OP_PEEK}) ? LEN_W'(1) : n_min;
                idx_next     = '0;
                consume_next = (op inside {OP_READ, OP_READ_BLK});
                if (op inside {OP_READ, OP_READ_BLK}) begin
                  fill_next = fill - CNT_W'(n_next);
                end
                state_next = S_BURST;
              end
            end
            OP_SKIP: begin
              rd_ptr_next  = adv_res;
              fill_next    = fill - CNT_W'(n_min);
              out_len_next = n_min;
            end
            default: begin
              // unused modes leave the ring alone
              out_status_next = ST_OK;
            end
          endcase
          out_level_next = LEVEL_W'(fill_next);
        end
      end
      S_BURST: begin
        adv_base  = p;
        mem_raddr = p;
        if (out_free) begin
          load          = 1'b1;
          out_data_next = rdata;
          out_len_next  = n_reg;
          out_last_next = burst_last;
          if (burst_last) begin
            state_next = S_IDLE;
            if (consume) begin
              rd_ptr_next = p;
            end
          end else begin
            mem_re   = 1'b1;
            p_next   = adv_res;
            idx_next = idx + LEN_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // a capacity write empties the ring
    if (cfg_we) begin
      rd_ptr_next = '0;
      wr_ptr_next = '0;
      fill_next   = '0;
    end
  end

  // storage ram
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= din;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      fill     <= '0;
      capacity <= CNT_W'(DEPTH);
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      fill   <= fill_next;
      if (cfg_we) begin
        capacity <= cfg_cap;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // burst bookkeeping and result payload
  always_ff @(posedge clk) begin
    p       <= p_next;
    idx     <= idx_next;
    n_reg   <= n_next;
    consume <= consume_next;
    if (load) begin
      out_data   <= out_data_next;
      out_status <= out_status_next;
      out_len    <= out_len_next;
      out_last   <= out_last_next;
      out_level  <= out_level_next;
    end
  end

  assign m_tdata = {2'b00, out_level, out_len, out_status, out_data};
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  // the ring never holds more than its capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= capacity)
    else $error("fill count above capacity");

  // both pointers stay inside the ring
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(rd_ptr) < capacity) && (CNT_W'(wr_ptr) < capacity))
    else $error("pointer outside ring");

  // the level reported across a burst cannot move
  a_burst_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_BURST && !cfg_we) |=> (fill == $past(fill)))
    else $error("fill changed during burst");

  // the final byte of a burst returns the sequencer to idle
  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_BURST && load && burst_last) |=> (state == S_IDLE))
    else $error("burst did not end on last byte");
`endif

endmodule

/* dv/tb.sv */
// self-checking testbench for the byte ring fifo: directed table, then random capacity phases
`timescale 1ns / 1ps

module tb;
  import brf_pkg::*;

  // modes outside the package enum, the block must answer them with an idle result
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int NO_CAP_WR    = -1;
  localparam int GAP_MAX      = 15;
  localparam int PHASE_REQS   = 30;
  localparam int DRAIN_CYCLES = DEF_MAX_BURST + 8;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic [ST_W-1:0]    status;
    logic [LEN_W-1:0]   length;
    logic               is_last;
    logic [LEVEL_W-1:0] level;
  } fifo_result_t;

  // one row of the directed table: capacity write before the request, if any
  typedef struct packed {
    logic [OP_W-1:0]   mode;
    logic [DATA_W-1:0] din;
    logic [LEN_W-1:0]  cnt;
    int                cap_wr;
    bit                typed;
    fifo_result_t      want;
  } dir_row_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [15:0]        s_tdata   = '0;   // [7:0] data_in, [14:8] count, [15] zero
  logic [OP_W-1:0]    s_tuser   = '0;   // [2:0] mode
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [31:0]        m_tdata;          // [7:0] data_out, [9:8] status, [16:10] length,
                                        // [29:17] level, [31:30] zero
  logic               m_tlast;
  logic               cfg_we    = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata = '0;

  byte_ring_fifo dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the ring, updated when a request is accepted
  logic [DATA_W-1:0] shadow_mem [DEF_DEPTH];
  int                shadow_rd   = 0;
  int                shadow_wr   = 0;
  int                shadow_fill = 0;
  int                shadow_cap  = DEF_DEPTH;

  fifo_result_t pending_results[$];
  int           n_mismatch = 0;
  bit           gaps_on    = 1'b1;
  bit           stalls_on  = 1'b1;
  int           stall_left = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    n_mismatch++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  // works out the results of one request and steps the shadow ring;
  // with keep low only the state moves (the table row carries its own result)
  task automatic predict_fifo_op(input logic [OP_W-1:0] mode, input logic [DATA_W-1:0] din,
                                 input logic [LEN_W-1:0] cnt, input bit keep);
    int n;
    int p;
    int i;
    fifo_result_t r;
    n = (cnt > DEF_MAX_BURST) ? DEF_MAX_BURST : int'(cnt);
    r = '0;
    r.status  = ST_OK;
    r.is_last = 1'b1;
    case (mode)
      OP_WRITE: begin
        if (shadow_fill >= shadow_cap) begin
          r.status = ST_FULL;   // byte dropped
        end else begin
          shadow_mem[shadow_wr] = din;
          shadow_wr = (shadow_wr + 1) % shadow_cap;
          shadow_fill++;
          r.length = 1;
        end
      end
      OP_READ, OP_PEEK: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data   = shadow_mem[shadow_rd];
          r.length = 1;
          if (mode == OP_READ) begin
            shadow_rd = (shadow_rd + 1) % shadow_cap;
            shadow_fill--;
          end
        end
      end
      OP_SKIP: begin
        // skip on an empty ring is still ok, just moves nothing
        if (n > shadow_fill) n = shadow_fill;
        shadow_rd = (shadow_rd + n) % shadow_cap;
        shadow_fill -= n;
        r.length = LEN_W'(n);
      end
      OP_READ_BLK, OP_PEEK_BLK: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (n > shadow_fill) n = shadow_fill;
          // zero count on a non-empty ring falls through to a single ok result
          if (n > 0) begin
            p = shadow_rd;
            if (mode == OP_READ_BLK) begin
              shadow_rd = (shadow_rd + n) % shadow_cap;
              shadow_fill -= n;
            end
            // every burst byte reports the level after the whole burst
            if (keep) begin
              for (i = 0; i < n; i++) begin
                r.data    = shadow_mem[p];
                r.length  = LEN_W'(n);
                r.is_last = (i == n - 1);
                r.level   = LEVEL_W'(shadow_fill);
                pending_results.push_back(r);
                p = (p + 1) % shadow_cap;
              end
            end
            return;
          end
        end
      end
      default: ;
    endcase
    r.level = LEVEL_W'(shadow_fill);
    if (keep) pending_results.push_back(r);
  endtask

  // capacity write only once every result is out; the write also empties the ring
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_cap  = (value == 0) ? 1 : (value > DEF_DEPTH) ? DEF_DEPTH : int'(value);
    shadow_rd   = 0;
    shadow_wr   = 0;
    shadow_fill = 0;
  endtask

  // drive one request at the falling edge, hold it until the block takes it
  task automatic send_req(input logic [OP_W-1:0] mode, input logic [DATA_W-1:0] din,
                          input logic [LEN_W-1:0] cnt, input bit typed,
                          input fifo_result_t want);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {1'b0, cnt, din};
    do @(posedge clk); while (!s_tready);
    if (typed) pending_results.push_back(want);
    predict_fifo_op(mode, din, cnt, !typed);
    @(negedge clk);
  endtask

  function automatic dir_row_t tab_row(input logic [OP_W-1:0] mode,
                                       input logic [DATA_W-1:0] din,
                                       input logic [LEN_W-1:0] cnt, input int cap_wr,
                                       input bit typed, input logic [ST_W-1:0] st,
                                       input int len, input int lvl,
                                       input logic [DATA_W-1:0] dout);
    dir_row_t r;
    r.mode         = mode;
    r.din          = din;
    r.cnt          = cnt;
    r.cap_wr       = cap_wr;
    r.typed        = typed;
    r.want.data    = dout;
    r.want.status  = st;
    r.want.length  = LEN_W'(len);
    r.want.is_last = 1'b1;
    r.want.level   = LEVEL_W'(lvl);
    return r;
  endfunction

  // result side: random stall bursts, no new ones while stalls are switched off
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, GAP_MAX - 1);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: tdata %h", m_tdata));
      end else begin
        want = pending_results.pop_front();
        check_field("data_out", m_tdata[7:0], want.data);
        check_field("status", m_tdata[9:8], want.status);
        check_field("length", m_tdata[16:10], want.length);
        check_field("level", m_tdata[29:17], want.level);
        check_field("last", m_tlast, want.is_last);
      end
    end
  end

  initial begin
    dir_row_t         dir_tab[$];
    logic [CAP_W-1:0] caps[$];
    logic [OP_W-1:0]  read_ops[5];
    logic [OP_W-1:0]  mode;
    logic [LEN_W-1:0] cnt;
    int               wr_pct;
    bit               calm;

    read_ops = '{OP_READ, OP_PEEK, OP_SKIP, OP_READ_BLK, OP_PEEK_BLK};

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty ring after reset, every kind of read, peek and skip request
    dir_tab.push_back(tab_row(OP_READ,     8'h00, 7'd0,   NO_CAP_WR, 1, ST_EMPTY, 0, 0, 8'h00));
    dir_tab.push_back(tab_row(OP_PEEK,     8'h00, 7'd0,   NO_CAP_WR, 1, ST_EMPTY, 0, 0, 8'h00));
    dir_tab.push_back(tab_row(OP_SKIP,     8'h00, 7'd5,   NO_CAP_WR, 1, ST_OK,    0, 0, 8'h00));
    dir_tab.push_back(tab_row(OP_READ_BLK, 8'h00, 7'd3,   NO_CAP_WR, 1, ST_EMPTY, 0, 0, 8'h00));
    dir_tab.push_back(tab_row(OP_PEEK_BLK, 8'h00, 7'd3,   NO_CAP_WR, 1, ST_EMPTY, 0, 0, 8'h00));
    // unused modes change nothing; then three writes and a peek
    dir_tab.push_back(tab_row(OP_SPARE_LO, 8'h00, 7'd0,   NO_CAP_WR, 1, ST_OK,    0, 0, 8'h00));
    dir_tab.push_back(tab_row(OP_SPARE_HI, 8'hff, 7'd127, NO_CAP_WR, 1, ST_OK,    0, 0, 8'h00));
    dir_tab.push_back(tab_row(OP_WRITE,    8'hff, 7'd0,   NO_CAP_WR, 1, ST_OK,    1, 1, 8'h00));
    dir_tab.push_back(tab_row(OP_WRITE,    8'h00, 7'd127, NO_CAP_WR, 1, ST_OK,    1, 2, 8'h00));
    dir_tab.push_back(tab_row(OP_WRITE,    8'ha5, 7'd0,   NO_CAP_WR, 1, ST_OK,    1, 3, 8'h00));
    dir_tab.push_back(tab_row(OP_PEEK,     8'h00, 7'd0,   NO_CAP_WR, 1, ST_OK,    1, 3, 8'hff));
    // zero count bursts on a non-empty ring
    dir_tab.push_back(tab_row(OP_PEEK_BLK, 8'h00, 7'd0,   NO_CAP_WR, 1, ST_OK,    0, 3, 8'h00));
    dir_tab.push_back(tab_row(OP_READ_BLK, 8'h00, 7'd0,   NO_CAP_WR, 1, ST_OK,    0, 3, 8'h00));
    // count beyond the burst limit, cut to what is held
    dir_tab.push_back(tab_row(OP_PEEK_BLK, 8'h00, 7'd127, NO_CAP_WR, 0, ST_OK,    0, 0, 8'h00));
    dir_tab.push_back(tab_row(OP_READ,     8'h00, 7'd0,   NO_CAP_WR, 1, ST_OK,    1, 2, 8'hff));
    dir_tab.push_back(tab_row(OP_READ_BLK, 8'h00, 7'd127, NO_CAP_WR, 0, ST_OK,    0, 0, 8'h00));
    // capacity zero acts as one: second write is refused as full
    dir_tab.push_back(tab_row(OP_WRITE,    8'h5a, 7'd0,   0,         1, ST_OK,    1, 1, 8'h00));
    dir_tab.push_back(tab_row(OP_WRITE,    8'h11, 7'd0,   NO_CAP_WR, 1, ST_FULL,  0, 1, 8'h00));
    dir_tab.push_back(tab_row(OP_SKIP,     8'h00, 7'd64,  NO_CAP_WR, 1, ST_OK,    1, 0, 8'h00));
    // capacity above the ram size acts as the ram size
    dir_tab.push_back(tab_row(OP_WRITE,    8'h3c, 7'd0,   8191,      1, ST_OK,    1, 1, 8'h00));
    // capacity two: fill, refuse, skip, wrap the write pointer, burst across the wrap
    dir_tab.push_back(tab_row(OP_WRITE,    8'h01, 7'd0,   2,         1, ST_OK,    1, 1, 8'h00));
    dir_tab.push_back(tab_row(OP_WRITE,    8'h02, 7'd0,   NO_CAP_WR, 1, ST_OK,    1, 2, 8'h00));
    dir_tab.push_back(tab_row(OP_WRITE,    8'h03, 7'd0,   NO_CAP_WR, 1, ST_FULL,  0, 2, 8'h00));
    dir_tab.push_back(tab_row(OP_SKIP,     8'h00, 7'd1,   NO_CAP_WR, 1, ST_OK,    1, 1, 8'h00));
    dir_tab.push_back(tab_row(OP_WRITE,    8'h04, 7'd0,   NO_CAP_WR, 1, ST_OK,    1, 2, 8'h00));
    dir_tab.push_back(tab_row(OP_READ_BLK, 8'h00, 7'd2,   NO_CAP_WR, 0, ST_OK,    0, 0, 8'h00));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cap_wr != NO_CAP_WR) write_capacity(CAP_W'(dir_tab[i].cap_wr));
      send_req(dir_tab[i].mode, dir_tab[i].din, dir_tab[i].cnt, dir_tab[i].typed,
               dir_tab[i].want);
    end

    // random phases, one capacity each; small rings wrap and hit full often
    caps = '{13'd1, 13'd4096, 13'd2, 13'd5, 13'd0, 13'd64, 13'd8191, 13'd17, 13'd3,
             13'd100, 13'd9};
    foreach (caps[k]) begin
      write_capacity(caps[k]);
      calm      = (k == caps.size() - 1);
      gaps_on   = !calm && $urandom_range(0, 3) != 0;
      stalls_on = !calm && $urandom_range(0, 3) != 0;
      wr_pct    = $urandom_range(35, 65);
      repeat (PHASE_REQS) begin
        if ($urandom_range(0, 99) < wr_pct) begin
          mode = OP_WRITE;
        end else if ($urandom_range(0, 99) < 4) begin
          mode = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        end else begin
          mode = read_ops[$urandom_range(0, 4)];
        end
        // mostly short counts, now and then anything up to the field maximum
        cnt = ($urandom_range(0, 9) < 2) ? LEN_W'($urandom_range(0, 127))
                                          : LEN_W'($urandom_range(0, 12));
        send_req(mode, DATA_W'($urandom_range(0, 255)), cnt, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hung handshake guard
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
